// ----- src/pointer_gesture_direction_classifier_unit_defines.svh -----
// Assertion macros used by the top level of the pointer gesture classifier.
`ifndef POINTER_GESTURE_DIRECTION_CLASSIFIER_UNIT_DEFINES_SVH
`define POINTER_GESTURE_DIRECTION_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PGDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PGDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pgdc_pkg.sv -----
// Types, constants and tables of the pointer gesture classifier.
package pgdc_pkg;

  localparam int unsigned XY_W       = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned MIND_W     = 10;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned S_TDATA_W  = 72;
  localparam int unsigned M_TDATA_W  = 40;
  localparam int unsigned M_TUSER_W  = 3;
  localparam int unsigned DIR_W      = 4;

  // squared distance and limits
  localparam int unsigned DIST_W     = 33;
  localparam int unsigned M2_W       = 20;
  localparam int unsigned PCT2_W     = 14;
  localparam int unsigned SECTOR_W   = 14;

  // shared multiplier: 16 x 25 bit unsigned
  localparam int unsigned MUL_A_W    = 16;
  localparam int unsigned MUL_B_W    = 25;
  localparam int unsigned PROD_W     = 41;
  // floor(p * 144 / 125) == (p * SECTOR_RECIP) >> RECIP_SHIFT for p <= 10000
  localparam logic [MUL_B_W-1:0] SECTOR_RECIP = 25'd19327353;
  localparam int unsigned RECIP_SHIFT = 24;

  // angle iteration
  localparam int unsigned CORDIC_STEPS = 20;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned CX_W         = 36;
  localparam int unsigned CZ_W         = 25;
  localparam int unsigned ATAN_W       = 22;
  localparam int unsigned ANGLE_W      = 15;
  localparam int unsigned ANGLE_SHIFT  = 8;
  localparam int unsigned FRAC_W       = 16;
  localparam logic [ANGLE_W-1:0] QUARTER_Q      = 15'd23040;
  localparam logic [ANGLE_W-1:0] HALF_QUARTER_Q = 15'd11520;
  localparam logic signed [CZ_W-1:0] Z_MAX      = 25'sd5898240;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // register reset values
  localparam logic [MIND_W-1:0]         MIN_DISTANCE_RST  = 10'd20;
  localparam logic [PCT_W-1:0]          MAX_SLIP_RST      = 7'd85;
  localparam logic [PCT_W-1:0]          SPLIT_PERCENT_RST = 7'd50;
  localparam logic [LIMIT_W-1:0]        MAX_TIME_RST      = 16'd300;
  localparam logic signed [XY_W-1:0]    VIEW_LO_RST       = 16'sh8000;
  localparam logic signed [XY_W-1:0]    VIEW_HI_RST       = 16'sh7FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DISTANCE  = 3'd0,
    REG_MAX_SLIP      = 3'd1,
    REG_SPLIT_PERCENT = 3'd2,
    REG_MAX_TIME      = 3'd3,
    REG_VIEW_LEFT     = 3'd4,
    REG_VIEW_RIGHT    = 3'd5,
    REG_VIEW_TOP      = 3'd6,
    REG_VIEW_BOTTOM   = 3'd7
  } pgdc_reg_e;

  typedef enum logic {
    OP_PRESS   = 1'b0,
    OP_RELEASE = 1'b1
  } pgdc_op_e;

  typedef enum logic [M_TUSER_W-1:0] {
    OUT_PASS     = 3'd0,
    OUT_CAPTURED = 3'd1,
    OUT_MENU     = 3'd2,
    OUT_GESTURE  = 3'd3,
    OUT_REJECTED = 3'd4
  } pgdc_outcome_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE      = 4'd0,
    DIR_RIGHT     = 4'd1,
    DIR_UPRIGHT   = 4'd2,
    DIR_UP        = 4'd3,
    DIR_UPLEFT    = 4'd4,
    DIR_LEFT      = 4'd5,
    DIR_DOWNLEFT  = 4'd6,
    DIR_DOWN      = 4'd7,
    DIR_DOWNRIGHT = 4'd8
  } pgdc_dir_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_MUL    = 3'd1,
    ST_CORDIC = 3'd2,
    ST_DECIDE = 3'd3,
    ST_DONE   = 3'd4
  } pgdc_state_e;

  // multiplier schedule, one product per cycle
  typedef enum logic [2:0] {
    MUL_SQ_X   = 3'd0,
    MUL_SQ_Y   = 3'd1,
    MUL_SQ_MIN = 3'd2,
    MUL_PCT_A  = 3'd3,
    MUL_PCT_B  = 3'd4,
    MUL_LIM_A  = 3'd5,
    MUL_LIM_B  = 3'd6,
    MUL_LAST   = 3'd7
  } pgdc_mul_e;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] angle;
  } pgdc_cordic_sts_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/pgdc_cordic.sv -----
// Vectoring angle unit: one rotation step per cycle over a shared add/sub stage.
module pgdc_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pgdc_pkg::XY_W-1:0]           ax_i,
  input  logic [pgdc_pkg::XY_W-1:0]           ay_i,
  output pgdc_pkg::pgdc_cordic_sts_t          sts_o
);

  localparam int unsigned PadW = pgdc_pkg::CX_W - pgdc_pkg::XY_W - pgdc_pkg::FRAC_W;

  logic signed [pgdc_pkg::CX_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [pgdc_pkg::CZ_W-1:0] z_q, z_d;
  logic [pgdc_pkg::STEP_W-1:0]      step_q, step_d;
  logic                             run_q, run_d, done_q, done_d;

  logic signed [pgdc_pkg::CX_W-1:0] xs, ys, y_mag;
  logic signed [pgdc_pkg::CZ_W-1:0] atan_s, z_clip;
  logic                             y_pos;

  always_comb begin
    atan_s = $signed({{(pgdc_pkg::CZ_W - pgdc_pkg::ATAN_W){1'b0}},
                      pgdc_pkg::atan_lut(step_q)});
    xs     = x_q >>> step_q;
    // shift the magnitude so negative values truncate toward zero
    y_mag  = y_q[pgdc_pkg::CX_W-1] ? -y_q : y_q;
    ys     = y_mag >> step_q;
    if (y_q[pgdc_pkg::CX_W-1]) begin
      ys = -ys;
    end
    y_pos  = !y_q[pgdc_pkg::CX_W-1] && (y_q != '0);
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = $signed({{PadW{1'b0}}, ax_i, {pgdc_pkg::FRAC_W{1'b0}}});
      y_d    = $signed({{PadW{1'b0}}, ay_i, {pgdc_pkg::FRAC_W{1'b0}}});
      z_d    = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (y_pos) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_s;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_s;
      end
      step_d = pgdc_pkg::STEP_W'(step_q + 1'b1);
      if (step_q == pgdc_pkg::STEP_W'(pgdc_pkg::CORDIC_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // clamp to 0..90 degrees, then drop to 1/256 degree
  always_comb begin
    if (z_q[pgdc_pkg::CZ_W-1]) begin
      z_clip = '0;
    end else if (z_q > pgdc_pkg::Z_MAX) begin
      z_clip = pgdc_pkg::Z_MAX;
    end else begin
      z_clip = z_q;
    end
  end

  assign sts_o.done  = done_q;
  assign sts_o.angle = z_clip[pgdc_pkg::ANGLE_W + pgdc_pkg::ANGLE_SHIFT - 1:
                              pgdc_pkg::ANGLE_SHIFT];

endmodule

// ----- src/pointer_gesture_direction_classifier_unit.sv -----
// Top level of the pointer gesture classifier: sequencer, shared multiplier and decision.
//
// Usage:
//   s_axis carries one pointer event per transaction: tuser is the event kind
//   (press or release), tdata the position, timestamp and modifier flag.
//   m_axis returns exactly one result per event: tuser is the outcome, tdata
//   the direction and the context menu position.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write the eight registers; write them
//   only while no event is in flight.
// Sequence:
//   A press, or a release without an active capture, goes straight to the done
//   state and is answered from the result register; the next event is taken
//   once that result is in the output register. A captured release runs the
//   schedule on the shared 16x25 multiplier (squared distance, radius and sector
//   limits), then 20 steps of the angle unit, then the decision state, which
//   stages the result; the next event is taken once it is in the output register.
// Reset clears the capture and all control state and loads register defaults.
// A stalled receiver holds the result in the output register; a finished item
// then waits in the done state before the next one is accepted.
`include "pointer_gesture_direction_classifier_unit_defines.svh"

module pointer_gesture_direction_classifier_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x[15:0], pos_y[31:16], time_ms[63:32], modifier_held[64], zero fill
  input  logic [pgdc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // operation[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // direction[3:0], menu_x[19:4], menu_y[35:20], zero fill
  output logic [pgdc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // outcome[2:0]
  output logic [pgdc_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [pgdc_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [pgdc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  // configuration
  logic [pgdc_pkg::MIND_W-1:0]      min_dist_q;
  logic [pgdc_pkg::PCT_W-1:0]       max_slip_q, split_q;
  logic [pgdc_pkg::LIMIT_W-1:0]     max_time_q;
  logic signed [pgdc_pkg::XY_W-1:0] view_left_q, view_right_q, view_top_q, view_bottom_q;

  // control
  pgdc_pkg::pgdc_state_e state_q, state_d;
  pgdc_pkg::pgdc_mul_e   mul_step_q, mul_step_d;
  logic                  capture_q;
  logic                  in_fire, out_load, cordic_start;

  // capture and item data
  logic signed [pgdc_pkg::XY_W-1:0] press_x_q, press_y_q, rel_x_q, rel_y_q;
  logic [pgdc_pkg::TIME_W-1:0]      press_time_q, el_q;
  logic [pgdc_pkg::XY_W-1:0]        ax_q, ay_q;
  logic                             dx_pos_q, dy_pos_q;

  // multiplier results
  logic [pgdc_pkg::MUL_A_W-1:0]     mul_a;
  logic [pgdc_pkg::MUL_B_W-1:0]     mul_b;
  logic [pgdc_pkg::PROD_W-1:0]      prod_q;
  logic [pgdc_pkg::DIST_W-1:0]      dist_q;
  logic [pgdc_pkg::M2_W-1:0]        m2_q;
  logic [pgdc_pkg::PCT2_W-1:0]      pa_q, pb_q;
  logic [pgdc_pkg::SECTOR_W-1:0]    lim_a_q, lim_b_q;

  // result staging and output register
  pgdc_pkg::pgdc_outcome_e          res_outcome_q, res_outcome_d, m_outcome_q;
  pgdc_pkg::pgdc_dir_e              res_dir_q, res_dir_d, m_dir_q;
  logic signed [pgdc_pkg::XY_W-1:0] m_mx_q, m_my_q;
  logic                             m_valid_q;

  // input unpacking
  logic signed [pgdc_pkg::XY_W-1:0] in_x, in_y;
  logic [pgdc_pkg::TIME_W-1:0]      in_time;
  logic                             in_mod, in_release, press_ok;
  logic signed [pgdc_pkg::XY_W:0]   dx, dy;

  pgdc_pkg::pgdc_cordic_sts_t       cordic_sts;

  assign in_x       = $signed(s_axis_tdata[15:0]);
  assign in_y       = $signed(s_axis_tdata[31:16]);
  assign in_time    = s_axis_tdata[63:32];
  assign in_mod     = s_axis_tdata[64];
  assign in_release = (pgdc_pkg::pgdc_op_e'(s_axis_tuser[0]) == pgdc_pkg::OP_RELEASE);

  assign press_ok = !capture_q && !in_mod &&
                    (in_x >= view_left_q) && (in_x <= view_right_q) &&
                    (in_y >= view_top_q) && (in_y <= view_bottom_q);

  assign dx = {in_x[pgdc_pkg::XY_W-1], in_x} - {press_x_q[pgdc_pkg::XY_W-1], press_x_q};
  assign dy = {in_y[pgdc_pkg::XY_W-1], in_y} - {press_y_q[pgdc_pkg::XY_W-1], press_y_q};

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q    <= pgdc_pkg::MIN_DISTANCE_RST;
      max_slip_q    <= pgdc_pkg::MAX_SLIP_RST;
      split_q       <= pgdc_pkg::SPLIT_PERCENT_RST;
      max_time_q    <= pgdc_pkg::MAX_TIME_RST;
      view_left_q   <= pgdc_pkg::VIEW_LO_RST;
      view_right_q  <= pgdc_pkg::VIEW_HI_RST;
      view_top_q    <= pgdc_pkg::VIEW_LO_RST;
      view_bottom_q <= pgdc_pkg::VIEW_HI_RST;
    end else if (cfg_we_i) begin
      unique case (pgdc_pkg::pgdc_reg_e'(cfg_addr_i))
        pgdc_pkg::REG_MIN_DISTANCE:  min_dist_q    <= cfg_wdata_i[pgdc_pkg::MIND_W-1:0];
        pgdc_pkg::REG_MAX_SLIP:      max_slip_q    <= cfg_wdata_i[pgdc_pkg::PCT_W-1:0];
        pgdc_pkg::REG_SPLIT_PERCENT: split_q       <= cfg_wdata_i[pgdc_pkg::PCT_W-1:0];
        pgdc_pkg::REG_MAX_TIME:      max_time_q    <= cfg_wdata_i;
        pgdc_pkg::REG_VIEW_LEFT:     view_left_q   <= $signed(cfg_wdata_i);
        pgdc_pkg::REG_VIEW_RIGHT:    view_right_q  <= $signed(cfg_wdata_i);
        pgdc_pkg::REG_VIEW_TOP:      view_top_q    <= $signed(cfg_wdata_i);
        pgdc_pkg::REG_VIEW_BOTTOM:   view_bottom_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    mul_step_d = mul_step_q;
    unique case (state_q)
      pgdc_pkg::ST_IDLE: begin
        if (in_fire) begin
          mul_step_d = pgdc_pkg::MUL_SQ_X;
          state_d    = (in_release && capture_q) ? pgdc_pkg::ST_MUL : pgdc_pkg::ST_DONE;
        end
      end
      pgdc_pkg::ST_MUL: begin
        mul_step_d = pgdc_pkg::pgdc_mul_e'(3'(mul_step_q + 3'd1));
        if (mul_step_q == pgdc_pkg::MUL_LAST) begin
          state_d = pgdc_pkg::ST_CORDIC;
        end
      end
      pgdc_pkg::ST_CORDIC: begin
        if (cordic_sts.done) begin
          state_d = pgdc_pkg::ST_DECIDE;
        end
      end
      pgdc_pkg::ST_DECIDE: state_d = pgdc_pkg::ST_DONE;
      pgdc_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = pgdc_pkg::ST_IDLE;
        end
      end
      default: state_d = pgdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == pgdc_pkg::ST_IDLE);
    cordic_start  = (state_q == pgdc_pkg::ST_MUL) && (mul_step_q == pgdc_pkg::MUL_LAST);
    out_load      = (state_q == pgdc_pkg::ST_DONE) && (!m_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pgdc_pkg::ST_IDLE;
      mul_step_q <= pgdc_pkg::MUL_SQ_X;
      capture_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mul_step_q <= mul_step_d;
      if (in_fire) begin
        if (!in_release && press_ok) begin
          capture_q <= 1'b1;
        end else if (in_release) begin
          capture_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rel_x_q  <= in_x;
      rel_y_q  <= in_y;
      ax_q     <= dx[pgdc_pkg::XY_W] ? pgdc_pkg::XY_W'(-dx) : dx[pgdc_pkg::XY_W-1:0];
      ay_q     <= dy[pgdc_pkg::XY_W] ? pgdc_pkg::XY_W'(-dy) : dy[pgdc_pkg::XY_W-1:0];
      dx_pos_q <= !dx[pgdc_pkg::XY_W] && (dx != '0);
      dy_pos_q <= !dy[pgdc_pkg::XY_W] && (dy != '0);
      el_q     <= in_time - press_time_q;
      if (!in_release && press_ok) begin
        press_x_q    <= in_x;
        press_y_q    <= in_y;
        press_time_q <= in_time;
      end
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  logic [pgdc_pkg::PCT_W-1:0] slip_c, split_c;

  assign slip_c  = (max_slip_q > pgdc_pkg::PCT_FULL) ? pgdc_pkg::PCT_FULL : max_slip_q;
  assign split_c = (split_q > pgdc_pkg::PCT_FULL) ? pgdc_pkg::PCT_FULL : split_q;

  always_comb begin
    unique case (mul_step_q)
      pgdc_pkg::MUL_SQ_X: begin
        mul_a = ax_q;
        mul_b = pgdc_pkg::MUL_B_W'(ax_q);
      end
      pgdc_pkg::MUL_SQ_Y: begin
        mul_a = ay_q;
        mul_b = pgdc_pkg::MUL_B_W'(ay_q);
      end
      pgdc_pkg::MUL_SQ_MIN: begin
        mul_a = pgdc_pkg::MUL_A_W'(min_dist_q);
        mul_b = pgdc_pkg::MUL_B_W'(min_dist_q);
      end
      pgdc_pkg::MUL_PCT_A: begin
        mul_a = pgdc_pkg::MUL_A_W'(slip_c);
        mul_b = pgdc_pkg::MUL_B_W'(split_c);
      end
      pgdc_pkg::MUL_PCT_B: begin
        mul_a = pgdc_pkg::MUL_A_W'(slip_c);
        mul_b = pgdc_pkg::MUL_B_W'(pgdc_pkg::PCT_FULL - split_c);
      end
      pgdc_pkg::MUL_LIM_A: begin
        mul_a = pgdc_pkg::MUL_A_W'(pa_q);
        mul_b = pgdc_pkg::SECTOR_RECIP;
      end
      pgdc_pkg::MUL_LIM_B: begin
        mul_a = pgdc_pkg::MUL_A_W'(pb_q);
        mul_b = pgdc_pkg::SECTOR_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // each step picks up the product of the step before
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == pgdc_pkg::ST_MUL) begin
      unique case (mul_step_q)
        pgdc_pkg::MUL_SQ_Y:   dist_q  <= prod_q[pgdc_pkg::DIST_W-1:0];
        pgdc_pkg::MUL_SQ_MIN: dist_q  <= dist_q + prod_q[pgdc_pkg::DIST_W-1:0];
        pgdc_pkg::MUL_PCT_A:  m2_q    <= prod_q[pgdc_pkg::M2_W-1:0];
        pgdc_pkg::MUL_PCT_B:  pa_q    <= prod_q[pgdc_pkg::PCT2_W-1:0];
        pgdc_pkg::MUL_LIM_A:  pb_q    <= prod_q[pgdc_pkg::PCT2_W-1:0];
        pgdc_pkg::MUL_LIM_B:
          lim_a_q <= prod_q[pgdc_pkg::RECIP_SHIFT + pgdc_pkg::SECTOR_W - 1:pgdc_pkg::RECIP_SHIFT];
        pgdc_pkg::MUL_LAST:
          lim_b_q <= prod_q[pgdc_pkg::RECIP_SHIFT + pgdc_pkg::SECTOR_W - 1:pgdc_pkg::RECIP_SHIFT];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- angle unit
  pgdc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .ax_i    (ax_q),
    .ay_i    (ay_q),
    .sts_o   (cordic_sts)
  );

  // ---------------------------------------------------------------- decision
  logic [pgdc_pkg::M2_W+1:0]     m2x3;
  logic [pgdc_pkg::LIMIT_W+1:0]  limx3;
  logic [pgdc_pkg::ANGLE_W-1:0]  q, lim_a, lim_b;
  logic                          is_none, is_bad, over, way_over;
  pgdc_pkg::pgdc_dir_e           dir_raw;

  always_comb begin
    m2x3     = {2'b00, m2_q} + {1'b0, m2_q, 1'b0};
    limx3    = {2'b00, max_time_q} + {1'b0, max_time_q, 1'b0};
    lim_a    = pgdc_pkg::ANGLE_W'(lim_a_q);
    lim_b    = pgdc_pkg::ANGLE_W'(lim_b_q);
    over     = el_q > pgdc_pkg::TIME_W'(max_time_q);
    way_over = el_q > pgdc_pkg::TIME_W'(limx3[pgdc_pkg::LIMIT_W+1:1]);

    priority if (ax_q == '0) begin
      q = pgdc_pkg::QUARTER_Q;
    end else if (ay_q == '0) begin
      q = '0;
    end else begin
      q = cordic_sts.angle;
    end

    is_none = dist_q < pgdc_pkg::DIST_W'(m2_q);
    is_bad  = 1'b0;
    dir_raw = pgdc_pkg::DIR_NONE;
    priority if (is_none) begin
      dir_raw = pgdc_pkg::DIR_NONE;
    end else if (dist_q < pgdc_pkg::DIST_W'(m2x3[pgdc_pkg::M2_W+1:1])) begin
      is_bad = 1'b1;
    end else if (q <= lim_a) begin
      dir_raw = dx_pos_q ? pgdc_pkg::DIR_RIGHT : pgdc_pkg::DIR_LEFT;
    end else if (q >= pgdc_pkg::QUARTER_Q - lim_a) begin
      dir_raw = dy_pos_q ? pgdc_pkg::DIR_DOWN : pgdc_pkg::DIR_UP;
    end else if ((q >= pgdc_pkg::HALF_QUARTER_Q - lim_b) &&
                 (q <= pgdc_pkg::HALF_QUARTER_Q + lim_b)) begin
      if (dy_pos_q) begin
        dir_raw = dx_pos_q ? pgdc_pkg::DIR_DOWNRIGHT : pgdc_pkg::DIR_DOWNLEFT;
      end else begin
        dir_raw = dx_pos_q ? pgdc_pkg::DIR_UPRIGHT : pgdc_pkg::DIR_UPLEFT;
      end
    end else begin
      is_bad = 1'b1;
    end

    // far over the time limit drops to a plain click, slightly over rejects
    if (over) begin
      if (way_over) begin
        is_none = 1'b1;
        is_bad  = 1'b0;
      end else if (!is_none) begin
        is_bad = 1'b1;
      end
    end
  end

  always_comb begin
    res_outcome_d = res_outcome_q;
    res_dir_d     = res_dir_q;
    if (in_fire) begin
      res_dir_d     = pgdc_pkg::DIR_NONE;
      res_outcome_d = (!in_release && press_ok) ? pgdc_pkg::OUT_CAPTURED : pgdc_pkg::OUT_PASS;
    end else if (state_q == pgdc_pkg::ST_DECIDE) begin
      priority if (is_none) begin
        res_outcome_d = pgdc_pkg::OUT_MENU;
        res_dir_d     = pgdc_pkg::DIR_NONE;
      end else if (is_bad) begin
        res_outcome_d = pgdc_pkg::OUT_REJECTED;
        res_dir_d     = pgdc_pkg::DIR_NONE;
      end else begin
        res_outcome_d = pgdc_pkg::OUT_GESTURE;
        res_dir_d     = dir_raw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_outcome_q <= res_outcome_d;
    res_dir_q     <= res_dir_d;
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_outcome_q <= res_outcome_q;
      m_dir_q     <= res_dir_q;
      m_mx_q      <= (res_outcome_q == pgdc_pkg::OUT_MENU) ? rel_x_q : '0;
      m_my_q      <= (res_outcome_q == pgdc_pkg::OUT_MENU) ? rel_y_q : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_outcome_q;
  assign m_axis_tdata  = {4'b0000, m_my_q, m_mx_q, m_dir_q};

  // ---------------------------------------------------------------- checks
  `PGDC_ASSERT_NEXT(a_release_runs_mul, in_fire && in_release && capture_q,
    state_q == pgdc_pkg::ST_MUL, "captured release did not start the multiplier schedule")

  `PGDC_ASSERT_NOW(a_capture_from_press, capture_q && !$past(capture_q),
    $past(in_fire) && !$past(in_release), "capture set without an accepted press")

  `PGDC_ASSERT_NOW(a_dir_only_gesture,
    m_axis_tvalid && (m_outcome_q != pgdc_pkg::OUT_GESTURE),
    m_dir_q == pgdc_pkg::DIR_NONE, "direction reported on a non-gesture result")

  `PGDC_ASSERT_NOW(a_cordic_done_in_wait, cordic_sts.done,
    state_q == pgdc_pkg::ST_CORDIC, "angle unit finished outside its wait state")

endmodule
